@@ rtl/core/fbpc_pkg.sv @@
package fbpc_pkg;

  localparam int unsigned NumFracturesDef = 64;

  localparam logic [43:0] PermFracHigh = 44'd167772160000;
  localparam logic [43:0] PermFracLow  = 44'd1678;
  localparam logic [43:0] PermMatrixRst = 44'd16777216;

  localparam logic [2:0] CfgFracCount  = 3'd0;
  localparam logic [2:0] CfgMatrixPerm = 3'd1;
  localparam logic [2:0] CfgHighPerm   = 3'd2;
  localparam logic [2:0] CfgFracPor    = 3'd3;
  localparam logic [2:0] CfgMatrixPor  = 3'd4;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam int unsigned NumRegions = 22;

  typedef struct packed {
    logic               func;
    logic        [7:0]  row_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic        [30:0] extent;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } fbpc_in_t;

  typedef struct packed {
    logic signed [5:0]  region_id;
    logic        [6:0]  fracture_hits;
    logic               in_fracture;
    logic        [16:0] porosity;
    logic        [43:0] permeability;
    logic               error_flag;
  } fbpc_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_row;
    logic latch_point;
    logic read_row;
    logic clear_acc;
    logic emit;
  } fbpc_cmd_t;

  // Region bounds in eighths: min x,y,z then max x,y,z.
  function automatic logic [3:0] region_bound(input int unsigned r, input int unsigned k);
    logic [3:0] b [22][6];
    b[0]  = '{0,0,0,4,4,4}; b[1]  = '{4,0,0,8,4,4}; b[2]  = '{0,4,0,4,8,4};
    b[3]  = '{4,4,0,8,8,4}; b[4]  = '{0,0,4,4,4,8}; b[5]  = '{4,0,4,8,4,8};
    b[6]  = '{0,4,4,4,8,8}; b[7]  = '{6,6,6,8,8,8}; b[8]  = '{6,4,6,8,6,8};
    b[9]  = '{4,6,6,6,8,8}; b[10] = '{4,4,6,6,6,8}; b[11] = '{6,6,4,8,8,6};
    b[12] = '{6,4,4,8,6,6}; b[13] = '{4,6,4,6,8,6}; b[14] = '{4,4,4,5,5,5};
    b[15] = '{5,4,4,6,5,5}; b[16] = '{4,5,4,5,6,5}; b[17] = '{5,5,4,6,6,5};
    b[18] = '{4,4,5,5,5,6}; b[19] = '{5,4,5,6,5,6}; b[20] = '{4,5,5,5,6,6};
    b[21] = '{5,5,5,6,6,6};
    return b[r][k];
  endfunction

endpackage

@@ rtl/core/fbpc_ctrl.sv @@
module fbpc_ctrl
  import fbpc_pkg::*;
#(
  parameter int unsigned NumFractures = NumFracturesDef,
  localparam int unsigned RowW = $clog2(3 * NumFractures)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            func_i,
  input  logic [6:0]      frac_count_i,
  output logic            busy_o,
  output logic [RowW-1:0] rd_row_o,
  output fbpc_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StRead, StMul, StSum, StLast, StEmit
  } state_e;

  localparam int unsigned Rows = 3 * NumFractures;
  localparam int unsigned CntW = $clog2(Rows + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] row_q, row_d;
  logic [CntW-1:0] limit_q;
  logic [CntW-1:0] limit_d;
  logic [CntW+1:0] lim_w;
  fbpc_cmd_t       cmd_q, cmd_d;

  always_comb begin
    lim_w = '0;
    if ({25'd0, frac_count_i} > NumFractures) begin
      lim_w = (CntW + 2)'(Rows);
    end else begin
      lim_w = (CntW + 2)'(frac_count_i) * (CntW + 2)'(3);
    end
    limit_d = lim_w[CntW-1:0];
  end

  assign busy_o   = (state_q != StIdle);
  assign rd_row_o = row_q[RowW-1:0];

  // The accepted transaction is captured at the accepting edge itself.
  always_comb begin
    cmd_o             = cmd_q;
    cmd_o.load_row    = (state_q == StIdle) && start_i && (func_i == FuncLoad);
    cmd_o.latch_point = (state_q == StIdle) && start_i && (func_i == FuncQuery);
  end

  // Row pipeline: read (mem latency), multiply, sum, compare.
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cmd_d   = '0;
    case (state_q)
      StIdle: begin
        if (start_i && (func_i == FuncQuery)) begin
          cmd_d.clear_acc = 1'b1;
          row_d   = '0;
          state_d = (limit_d == '0) ? StLast : StRead;
        end
      end
      StRead: begin
        cmd_d.read_row = 1'b1;
        row_d = row_q + 1'b1;
        if (row_d == limit_q) begin
          state_d = StMul;
        end
      end
      StMul: state_d = StSum;
      StSum: state_d = StLast;
      StLast: state_d = StEmit;
      StEmit: begin
        cmd_d.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      limit_q <= '0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      cmd_q   <= cmd_d;
      if ((state_q == StIdle) && start_i && (func_i == FuncQuery)) begin
        limit_q <= limit_d;
      end
    end
  end

endmodule

@@ rtl/core/fbpc_dp.sv @@
module fbpc_dp
  import fbpc_pkg::*;
#(
  parameter int unsigned NumFractures = NumFracturesDef,
  localparam int unsigned RowW = $clog2(3 * NumFractures)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fbpc_in_t        in_i,
  input  fbpc_cmd_t       cmd_i,
  input  logic [RowW-1:0] rd_row_i,
  input  logic [43:0]     matrix_perm_i,
  input  logic            high_perm_i,
  input  logic [16:0]     frac_por_i,
  input  logic [16:0]     matrix_por_i,
  output logic            valid_o,
  output fbpc_out_t       out_o
);

  localparam int unsigned Rows = 3 * NumFractures;
  localparam int unsigned HitW = $clog2(NumFractures + 1);

  logic [158:0] mem [Rows];
  logic [158:0] rd_q;

  logic signed [31:0] px_q, py_q, pz_q;
  logic               rd_v_q, mul_v_q;
  logic signed [63:0] mx_q, my_q, mz_q, md_q;
  logic        [59:0] thr_q;
  logic signed [66:0] sum_q;
  logic        [59:0] thr2_q;
  logic        [1:0]  axis_q;
  logic               frac_ok_q;
  logic        [HitW-1:0] hits_q;
  logic signed [5:0]  region_q;
  logic               rerr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && ({24'd0, in_i.row_index} < Rows)) begin
      mem[RowW'(in_i.row_index)] <= {in_i.normal_x, in_i.normal_y, in_i.normal_z,
                                     in_i.plane_offset, in_i.extent};
    end
    rd_q <= mem[rd_row_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_point) begin
      px_q <= in_i.point_x;
      py_q <= in_i.point_y;
      pz_q <= in_i.point_z;
    end
    mx_q   <= $signed(rd_q[158:127]) * px_q;
    my_q   <= $signed(rd_q[126:95]) * py_q;
    mz_q   <= $signed(rd_q[94:63]) * pz_q;
    md_q   <= {{2{rd_q[62]}}, rd_q[62:31], 30'd0};
    thr_q  <= {rd_q[30:0], 29'd0};
    sum_q  <= 67'(mx_q) + 67'(my_q) + 67'(mz_q) - 67'(md_q);
    thr2_q <= thr_q;
  end

  // Region search over 22 constant boxes, done once at point latch.
  logic signed [5:0] reg_d;
  logic              rerr_d;
  logic              ins;
  logic signed [31:0] pc;
  logic signed [32:0] lo_b, hi_b;
  always_comb begin
    reg_d  = -6'sd1;
    rerr_d = 1'b0;
    for (int r = 0; r < NumRegions; r++) begin
      ins = 1'b1;
      for (int k = 0; k < 3; k++) begin
        pc = (k == 0) ? in_i.point_x : (k == 1) ? in_i.point_y : in_i.point_z;
        lo_b = $signed({8'd0, region_bound(r, k), 21'd0});
        hi_b = $signed({8'd0, region_bound(r, k + 3), 21'd0});
        if (!(lo_b < 33'(pc) && 33'(pc) < hi_b)) ins = 1'b0;
      end
      if (ins) begin
        if (reg_d != -6'sd1) rerr_d = 1'b1;
        else reg_d = 6'(r);
      end
    end
  end

  logic [66:0] mag;
  logic        in_box;
  assign mag    = sum_q[66] ? -sum_q : sum_q;
  assign in_box = (mag < {7'd0, thr2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; mul_v_q <= 1'b0; axis_q <= '0; frac_ok_q <= 1'b1;
      hits_q <= '0; region_q <= -6'sd1; rerr_q <= 1'b0; valid_o <= 1'b0;
      out_o <= '0;
    end else begin
      rd_v_q  <= cmd_i.read_row;
      mul_v_q <= rd_v_q;
      valid_o <= cmd_i.emit;
      if (cmd_i.clear_acc) begin
        axis_q <= '0; frac_ok_q <= 1'b1; hits_q <= '0;
      end else if (mul_v_q) begin
        if (axis_q == 2'd2) begin
          axis_q <= '0;
          frac_ok_q <= 1'b1;
          if (frac_ok_q && in_box) hits_q <= hits_q + 1'b1;
        end else begin
          axis_q <= axis_q + 1'b1;
          frac_ok_q <= frac_ok_q && in_box;
        end
      end
      if (cmd_i.latch_point) begin
        region_q <= reg_d;
        rerr_q   <= rerr_d;
      end
      if (cmd_i.emit) begin
        out_o.region_id     <= region_q;
        out_o.fracture_hits <= (HitW > 7 && hits_q > 127) ? 7'd127 : 7'(hits_q);
        out_o.in_fracture   <= (hits_q != '0);
        out_o.porosity      <= (hits_q != '0) ? frac_por_i : matrix_por_i;
        out_o.permeability  <= (hits_q != '0) ? (high_perm_i ? PermFracHigh : PermFracLow)
                                              : matrix_perm_i;
        out_o.error_flag    <= rerr_q || (hits_q > 3);
      end
    end
  end

endmodule

@@ rtl/core/fracture_box_point_classifier.sv @@
// Fracture box point classifier.
// Command channel: drive in_i with start_i high while busy_o is low; that
// transaction is accepted at that edge. func 0 loads one fracture axis row
// (busy_o stays low, loads can be accepted every cycle, no result); func 1
// queries a point.
// A query reads one stored row per cycle from a row memory with one write
// and one read port, 3*N rows with N = min(fracture_count, NUM_FRACTURES),
// then passes the memory read, multiply, sum and hit-count stages and the
// output register. With N = 0 no rows are read. busy_o falls as the
// controller registers the emit command, ahead of done_o, so the next
// command can be accepted at the edge that raises done_o; a query is
// accepted only once the one before it has left the controller.
// The result appears on out_o for one cycle with done_o high; the receiver
// cannot stall, so nothing is held back.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write a register at once;
// write only while no query is in flight.
// Reset (rst_ni low, asynchronous) returns the controller to idle and the
// registers to their defaults. Fracture rows are undefined until loaded.
module fracture_box_point_classifier
  import fbpc_pkg::*;
#(
  parameter int unsigned NUM_FRACTURES = NumFracturesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  fbpc_in_t    in_i,
  output logic        done_o,
  output fbpc_out_t   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [43:0] cfg_data_i
);

  localparam int unsigned RowW = $clog2(3 * NUM_FRACTURES);

  logic [6:0]  frac_count_q;
  logic [43:0] matrix_perm_q;
  logic        high_perm_q;
  logic [16:0] frac_por_q;
  logic [16:0] matrix_por_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_count_q  <= '0;
      matrix_perm_q <= PermMatrixRst;
      high_perm_q   <= 1'b1;
      frac_por_q    <= '0;
      matrix_por_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFracCount:  frac_count_q  <= cfg_data_i[6:0];
        CfgMatrixPerm: matrix_perm_q <= cfg_data_i;
        CfgHighPerm:   high_perm_q   <= cfg_data_i[0];
        CfgFracPor:    frac_por_q    <= cfg_data_i[16:0];
        CfgMatrixPor:  matrix_por_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  fbpc_cmd_t       cmd;
  logic [RowW-1:0] rd_row;
  logic            accept;

  assign accept = start_i && !busy_o;

  fbpc_ctrl #(.NumFractures(NUM_FRACTURES)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i      (accept),
    .func_i       (in_i.func),
    .frac_count_i (frac_count_q),
    .busy_o,
    .rd_row_o     (rd_row),
    .cmd_o        (cmd)
  );

  fbpc_dp #(.NumFractures(NUM_FRACTURES)) u_dp (
    .clk_i, .rst_ni,
    .in_i,
    .cmd_i         (cmd),
    .rd_row_i      (rd_row),
    .matrix_perm_i (matrix_perm_q),
    .high_perm_i   (high_perm_q),
    .frac_por_i    (frac_por_q),
    .matrix_por_i  (matrix_por_q),
    .valid_o       (done_o),
    .out_o
  );

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == FuncLoad) |=> !busy_o) else $error("load left busy");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func == FuncQuery) |=> busy_o) else $error("query not started");
  a_flag_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.fracture_hits > 3) |-> out_o.error_flag) else $error("flag missing");
`endif

endmodule

@@ tb/sv/fbpc_checker.sv @@
`timescale 1ns / 1ps

module fbpc_checker
  import fbpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  fbpc_in_t    in_i,
  input  logic        done_i,
  input  fbpc_out_t   out_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [43:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int     Rows   = 3 * NumFracturesDef;
  localparam longint Eighth = 64'sd2097152;

  logic signed [31:0] nx_mem  [Rows];
  logic signed [31:0] ny_mem  [Rows];
  logic signed [31:0] nz_mem  [Rows];
  logic signed [31:0] off_mem [Rows];
  logic        [30:0] ext_mem [Rows];

  logic [6:0]  frac_count;
  logic [43:0] mat_perm;
  logic        hi_perm;
  logic [16:0] frac_por;
  logic [16:0] mat_por;

  fbpc_out_t expected_q[$];

  // Region bounds in eighths: min x,y,z then max x,y,z.
  byte box [22][6] = '{
    '{0,0,0,4,4,4}, '{4,0,0,8,4,4}, '{0,4,0,4,8,4}, '{4,4,0,8,8,4},
    '{0,0,4,4,4,8}, '{4,0,4,8,4,8}, '{0,4,4,4,8,8}, '{6,6,6,8,8,8},
    '{6,4,6,8,6,8}, '{4,6,6,6,8,8}, '{4,4,6,6,6,8}, '{6,6,4,8,8,6},
    '{6,4,4,8,6,6}, '{4,6,4,6,8,6}, '{4,4,4,5,5,5}, '{5,4,4,6,5,5},
    '{4,5,4,5,6,5}, '{5,5,4,6,6,5}, '{4,4,5,5,5,6}, '{5,4,5,6,5,6},
    '{4,5,5,5,6,6}, '{5,5,5,6,6,6}
  };

  // The projection residual is kept exact at 96 bits and compared with e/2.
  function automatic bit row_contains(int row, longint px, longint py, longint pz);
    logic signed [95:0] acc;
    logic        [95:0] mag;
    logic        [95:0] thr;
    acc = 0;
    acc = acc + longint'(nx_mem[row]) * px;
    acc = acc + longint'(ny_mem[row]) * py;
    acc = acc + longint'(nz_mem[row]) * pz;
    acc = acc - longint'(off_mem[row]) * 64'sd1073741824;
    mag = (acc < 0) ? -acc : acc;
    thr = {65'd0, ext_mem[row]} << 29;
    return mag < thr;
  endfunction

  function automatic fbpc_out_t classify_point(fbpc_in_t it);
    fbpc_out_t res;
    longint    p [3];
    int        region;
    int        hits;
    int        active;
    bit        err;
    bit        in_region;
    p[0] = longint'(it.point_x);
    p[1] = longint'(it.point_y);
    p[2] = longint'(it.point_z);
    region = -1;
    hits = 0;
    err = 1'b0;
    for (int r = 0; r < 22; r++) begin
      in_region = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (!(box[r][k] * Eighth < p[k] && p[k] < box[r][k+3] * Eighth)) in_region = 1'b0;
      end
      if (in_region) begin
        if (region != -1) err = 1'b1;
        else region = r;
      end
    end
    active = (frac_count > NumFracturesDef) ? NumFracturesDef : frac_count;
    for (int f = 0; f < active; f++) begin
      if (row_contains(3*f, p[0], p[1], p[2]) && row_contains(3*f+1, p[0], p[1], p[2]) &&
          row_contains(3*f+2, p[0], p[1], p[2])) hits++;
    end
    if (hits > 3) err = 1'b1;
    res.region_id     = region[5:0];
    res.fracture_hits = (hits > 127) ? 7'd127 : hits[6:0];
    res.in_fracture   = (hits > 0);
    res.porosity      = (hits > 0) ? frac_por : mat_por;
    res.permeability  = (hits > 0) ? (hi_perm ? PermFracHigh : PermFracLow) : mat_perm;
    res.error_flag    = err;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    fbpc_out_t want;
    if (!rst_ni) begin
      frac_count = '0;
      mat_perm   = PermMatrixRst;
      hi_perm    = 1'b1;
      frac_por   = '0;
      mat_por    = '0;
      expected_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFracCount:  frac_count = cfg_data_i[6:0];
          CfgMatrixPerm: mat_perm   = cfg_data_i;
          CfgHighPerm:   hi_perm    = cfg_data_i[0];
          CfgFracPor:    frac_por   = cfg_data_i[16:0];
          CfgMatrixPor:  mat_por    = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (in_i.func == FuncLoad) begin
          if (in_i.row_index < Rows) begin
            nx_mem[in_i.row_index]  = in_i.normal_x;
            ny_mem[in_i.row_index]  = in_i.normal_y;
            nz_mem[in_i.row_index]  = in_i.normal_z;
            off_mem[in_i.row_index] = in_i.plane_offset;
            ext_mem[in_i.row_index] = in_i.extent;
          end
        end else begin
          expected_q = {expected_q, classify_point(in_i)};
        end
      end
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_i !== want) begin
            $display("%0t: mismatch expected region %0d hits %0d in %0b por %h perm %h err %0b",
                     $time, want.region_id, want.fracture_hits, want.in_fracture,
                     want.porosity, want.permeability, want.error_flag);
            $display("%0t:          actual region %0d hits %0d in %0b por %h perm %h err %0b",
                     $time, out_i.region_id, out_i.fracture_hits, out_i.in_fracture,
                     out_i.porosity, out_i.permeability, out_i.error_flag);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ tb/sv/fracture_box_point_classifier_tb.sv @@
`timescale 1ns / 1ps

module fracture_box_point_classifier_tb;
  import fbpc_pkg::*;

  localparam int     Rows      = 3 * NumFracturesDef;
  localparam int     IdleLimit = 4000;
  localparam longint One       = 64'sd16777216;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  fbpc_in_t    in_i = '0;
  logic        done_o;
  fbpc_out_t   out_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CfgFracCount;
  logic [43:0] cfg_data_i = '0;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  longint center   [NumFracturesDef][3];
  longint row_ext  [Rows];
  bit     row_flat [Rows];

  fracture_box_point_classifier dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  fbpc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .done_i(done_o), .out_i(out_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic idle(int n);
    start_i  <= 1'b0;
    cfg_we_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_item(fbpc_in_t it);
    start_i  <= 1'b1;
    cfg_we_i <= 1'b0;
    in_i     <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) idle($urandom_range(1, 8));
  endtask

  // Wait until every query has reported; loads leave no trace, so pad a bit.
  task automatic settle();
    idle(1);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [43:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  function automatic fbpc_in_t noise_item();
    fbpc_in_t     it;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(fbpc_in_t)-1:0];
    return it;
  endfunction

  // Mode 0 is a random box, mode 1 a small aligned box at the cube center,
  // mode 2 a huge aligned box at the cube center.
  task automatic load_fracture(int f, int mode);
    fbpc_in_t it;
    longint   n [3];
    longint   dot;
    int       k2;
    for (int k = 0; k < 3; k++) center[f][k] = (mode != 0) ? One / 2 : $urandom_range(0, One);
    for (int k = 0; k < 3; k++) begin
      it = noise_item();
      it.func = FuncLoad;
      it.row_index = 8'(3*f + k);
      n[0] = 0; n[1] = 0; n[2] = 0;
      row_flat[3*f+k] = (mode != 0) || ($urandom_range(0, 4) != 0);
      if (row_flat[3*f+k]) begin
        n[k] = $urandom_range(0, 1) ? 64'sd1073741824 : -64'sd1073741824;
      end else begin
        k2 = (k + 1) % 3;
        n[k] = 64'sd644245094;
        n[k2] = $urandom_range(0, 1) ? 64'sd858993459 : -64'sd858993459;
      end
      dot = (n[0]*center[f][0] + n[1]*center[f][1] + n[2]*center[f][2]) >>> 30;
      case (mode)
        1: row_ext[3*f+k] = One / 4;
        2: row_ext[3*f+k] = 64'sd268435456;
        default: begin
          case ($urandom_range(0, 9))
            0: row_ext[3*f+k] = 0;
            1: row_ext[3*f+k] = $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
            default: row_ext[3*f+k] = $urandom_range(One / 8, One + One / 4);
          endcase
        end
      endcase
      it.normal_x = n[0][31:0];
      it.normal_y = n[1][31:0];
      it.normal_z = n[2][31:0];
      it.plane_offset = dot[31:0];
      it.extent = row_ext[3*f+k][30:0];
      send_item(it);
    end
  endtask

  function automatic logic [31:0] region_coord();
    longint v;
    v = longint'($urandom_range(0, 8)) * 64'sd2097152;
    case ($urandom_range(0, 3))
      0: ;
      1: v = v + 1;
      2: v = v - 1;
      default: v = v + $urandom_range(0, 2097150) - 1048575;
    endcase
    return v[31:0];
  endfunction

  // Points near a box face: exactly on it, one step either side, or inside.
  function automatic logic [31:0] face_coord(int f, int k);
    longint h;
    longint v;
    h = row_ext[3*f+k] / 2;
    if ($urandom_range(0, 1)) h = -h;
    case ($urandom_range(0, 3))
      0: v = center[f][k] + h;
      1: v = center[f][k] + h + 1;
      2: v = center[f][k] + h - 1;
      default: v = center[f][k] + h / 2;
    endcase
    return v[31:0];
  endfunction

  task automatic query_point(longint x, longint y, longint z);
    fbpc_in_t it;
    it = noise_item();
    it.func = FuncQuery;
    it.point_x = x[31:0];
    it.point_y = y[31:0];
    it.point_z = z[31:0];
    send_item(it);
  endtask

  task automatic random_query();
    int f;
    f = $urandom_range(0, NumFracturesDef - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: query_point(region_coord(), region_coord(), region_coord());
      4, 5, 6, 7: query_point(face_coord(f, 0), face_coord(f, 1), face_coord(f, 2));
      8: query_point(face_coord(f, 0), region_coord(), face_coord(f, 2));
      default: query_point($urandom, $urandom, $urandom);
    endcase
  endtask

  task automatic random_config();
    logic [43:0] perm;
    logic [16:0] por [2];
    perm = 44'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: perm = '0;
      1: perm = '1;
      default: ;
    endcase
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(0, 4))
        0: por[i] = '0;
        1: por[i] = 17'd65536;
        2: por[i] = '1;
        default: por[i] = 17'($urandom_range(0, 65536));
      endcase
    end
    settle();
    case ($urandom_range(0, 5))
      0: write_reg(CfgFracCount, 44'd64);
      1: write_reg(CfgFracCount, 44'd127);
      2: write_reg(CfgFracCount, 44'd1);
      default: write_reg(CfgFracCount, 44'($urandom_range(0, 127)));
    endcase
    write_reg(CfgMatrixPerm, perm);
    write_reg(CfgHighPerm, 44'($urandom_range(0, 1)));
    write_reg(CfgFracPor, por[0]);
    write_reg(CfgMatrixPor, por[1]);
  endtask

  initial begin
    fbpc_in_t it;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, with no fractures active yet.
    query_point(One / 4, One / 4, One / 4);
    settle();
    write_reg(CfgMatrixPerm, 44'd12345);
    write_reg(CfgMatrixPor, 44'd65536);
    write_reg(CfgFracPor, 44'd32768);
    query_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);

    for (int f = 0; f < NumFracturesDef; f++) load_fracture(f, (f == 0) ? 1 : 0);
    for (int f = 1; f <= 4; f++) load_fracture(f, 2);

    // Loads beyond the last row must be ignored.
    it = noise_item();
    it.func = FuncLoad;
    it.row_index = 8'd200;
    send_item(it);
    it.row_index = 8'hFF;
    send_item(it);

    settle();
    write_reg(CfgFracCount, 44'd1);
    query_point(One / 2, One / 2, One / 2);
    query_point(One / 2 + One / 8, One / 2, One / 2);
    query_point(One / 2 + One / 8 - 1, One / 2, One / 2);
    query_point(One / 2, One / 2 - One / 8, One / 2);
    settle();
    write_reg(CfgFracCount, 44'd127);
    write_reg(CfgHighPerm, 44'd0);
    query_point(One / 2 + 1, One / 2 + 1, One / 2 + 1);
    query_point(0, 0, 0);
    query_point(One - 1, One - 1, One - 1);
    query_point(1, 1, 1);
    settle();
    write_reg(CfgFracCount, 44'd0);
    write_reg(CfgHighPerm, 44'd1);
    write_reg(CfgMatrixPerm, '1);
    write_reg(CfgMatrixPor, '1);
    query_point(One / 2, One / 2, One / 2);
    settle();
    write_reg(CfgFracCount, 44'd64);
    write_reg(CfgFracPor, '1);
    query_point(One / 2, One / 2, One / 2);

    for (int phase = 0; phase < 5; phase++) begin
      gaps_on = (phase < 4);
      random_config();
      for (int n = 0; n < 30; n++) begin
        case ($urandom_range(0, 9))
          0: load_fracture($urandom_range(0, NumFracturesDef - 1), 0);
          1: begin
            it = noise_item();
            it.func = FuncLoad;
            it.row_index = 8'($urandom_range(Rows, 255));
            send_item(it);
          end
          default: random_query();
        endcase
      end
    end

    settle();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/fbpc_pkg.sv
rtl/core/fbpc_ctrl.sv
rtl/core/fbpc_dp.sv
rtl/core/fracture_box_point_classifier.sv
tb/sv/fbpc_checker.sv
tb/sv/fracture_box_point_classifier_tb.sv
